// ===== rtl/core/iart_pkg.sv =====
// iart_pkg: shared types and constants of the interface address registration table
// holds request/response structs, operation and status codes, sequencer states
// no dependencies
package iart_pkg;

   // default table geometry
   localparam int NUM_ENTRIES_DEFAULT = 16;
   localparam int NUM_MODULES_DEFAULT = 16;

   // fixed field widths
   localparam int OP_W     = 3;
   localparam int IP_W     = 32;
   localparam int MOD_ID_W = 4;
   localparam int LIMIT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int IF_IDX_W = 5;

   // most addresses one list request returns
   localparam logic [LIMIT_W-1:0] MAX_LIST = 5'd16;

   // reserved lookup address
   localparam logic [IP_W-1:0] IP_ALL_ONES = 32'hffff_ffff;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_LOOKUP   = 3'd2,
      OP_LIST_MOD = 3'd3,
      OP_LIST_ALL = 3'd4
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NOT_FOUND  = 2'd2,
      ST_LIST_EMPTY = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } seq_state_type;

   // request payload
   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [IP_W-1:0]     ip_address;
      logic [MOD_ID_W-1:0] module_id;
      logic [LIMIT_W-1:0]  max_count;
   } req_type;

   // response payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IF_IDX_W-1:0] if_index;
      logic [IP_W-1:0]     listed_ip;
      logic                last;
   } rsp_type;

   // compare unit verdict on one table entry
   typedef struct packed {
      logic addr_eq;
      logic has_bit;
      logic count_zero;
      logic list_hit;
   } hit_type;

endpackage

// ===== rtl/core/iart_match.sv =====
// iart_match: compare unit shared by every table scan
// judges one entry against the held request; uses iart_pkg
module iart_match #(
   parameter int NUM_MODULES = iart_pkg::NUM_MODULES_DEFAULT,
   parameter int CNT_W       = 5
) (
   input  logic [iart_pkg::OP_W-1:0] operation,
   input  logic [iart_pkg::IP_W-1:0] ip_address,
   input  logic [NUM_MODULES-1:0]    module_mask,
   input  logic [iart_pkg::IP_W-1:0] entry_address,
   input  logic [NUM_MODULES-1:0]    entry_bits,
   input  logic [CNT_W-1:0]          entry_count,
   output iart_pkg::hit_type         hit
);
   import iart_pkg::*;

   // address compare, membership test, free test and list selection
   always_comb begin
      hit.addr_eq    = (entry_address == ip_address);
      hit.has_bit    = |(entry_bits & module_mask);
      hit.count_zero = (entry_count == '0);
      if (operation == OP_LIST_MOD) begin
         hit.list_hit = hit.has_bit;
      end else begin
         hit.list_hit = !hit.count_zero;
      end
   end

endmodule

// ===== rtl/core/iart_seq.sv =====
// iart_seq: table storage and the scan sequencer around the shared compare unit
// one entry read and judged per cycle unless stalled; uses iart_pkg, iart_match
module iart_seq #(
   parameter int NUM_ENTRIES = iart_pkg::NUM_ENTRIES_DEFAULT,
   parameter int NUM_MODULES = iart_pkg::NUM_MODULES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iart_pkg::req_type req_payload,
   output logic              push_valid,
   input  logic              push_ready,
   output iart_pkg::rsp_type push_rsp
);
   import iart_pkg::*;

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int PTR_W = $clog2(NUM_ENTRIES + 1);
   localparam int CNT_W = $clog2(NUM_MODULES + 1);
   localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_ENTRIES);

   // table storage
   logic [IP_W-1:0]        addr_mem [NUM_ENTRIES];
   logic [NUM_MODULES-1:0] bits_mem [NUM_ENTRIES];
   logic [CNT_W-1:0]       cnt_mem  [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] written_ff, written_in;

   // held request
   seq_state_type          state_ff, state_in;
   req_type                req_ff, req_in;
   logic [NUM_MODULES-1:0] mask_ff, mask_in;
   logic [LIMIT_W-1:0]     lim_ff, lim_in;

   // scan pipeline
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                   ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]       ev_idx_ff, ev_idx_in;
   logic [IP_W-1:0]        ev_addr_ff;
   logic [NUM_MODULES-1:0] ev_bits_ff;
   logic [CNT_W-1:0]       ev_count_ff;
   logic                   ev_known_ff;

   // scan results
   logic                   match_found_ff, match_found_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic [NUM_MODULES-1:0] match_bits_ff, match_bits_in;
   logic [CNT_W-1:0]       match_count_ff, match_count_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [NUM_MODULES-1:0] free_bits_ff, free_bits_in;
   logic [CNT_W-1:0]       free_count_ff, free_count_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IP_W-1:0]        pend_ip_ff, pend_ip_in;
   logic [LIMIT_W-1:0]     taken_ff, taken_in;

   // datapath signals
   logic                   accept;
   logic                   scan_done;
   logic                   is_list;
   logic                   take;
   logic                   need_push;
   logic                   adv;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_idx;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic [IP_W-1:0]        wr_addr;
   logic [NUM_MODULES-1:0] wr_bits;
   logic [CNT_W-1:0]       wr_count;
   logic [IP_W-1:0]        ent_addr;
   logic [NUM_MODULES-1:0] ent_bits;
   logic [CNT_W-1:0]       ent_count;
   logic                   add_write;
   logic                   match_has_bit;
   logic [IDX_W:0]         idx_plus;
   hit_type                hit;

   // entries never written read as zero
   assign ent_addr  = ev_known_ff ? ev_addr_ff  : '0;
   assign ent_bits  = ev_known_ff ? ev_bits_ff  : '0;
   assign ent_count = ev_known_ff ? ev_count_ff : '0;

   iart_match #(
      .NUM_MODULES(NUM_MODULES),
      .CNT_W      (CNT_W)
   ) u_match (
      .operation    (req_ff.operation),
      .ip_address   (req_ff.ip_address),
      .module_mask  (mask_ff),
      .entry_address(ent_addr),
      .entry_bits   (ent_bits),
      .entry_count  (ent_count),
      .hit          (hit)
   );

   // scan control
   assign accept    = (state_ff == S_IDLE) && req_valid;
   assign scan_done = (rd_ptr_ff == PTR_END) && !ev_valid_ff;
   assign is_list   = (req_ff.operation == OP_LIST_MOD) || (req_ff.operation == OP_LIST_ALL);
   assign take      = (state_ff == S_SCAN) && ev_valid_ff && is_list && hit.list_hit
                      && (taken_ff < lim_ff);
   assign need_push = take && pend_valid_ff;
   assign adv       = !(need_push && !push_ready);
   assign rd_en     = (state_ff == S_SCAN) && adv && (rd_ptr_ff != PTR_END);
   assign rd_idx    = rd_ptr_ff[IDX_W-1:0];

   // add commit decision
   assign match_has_bit = |(match_bits_ff & mask_ff);
   assign add_write     = (req_ff.operation == OP_ADD) && (|mask_ff)
                          && ((match_found_ff && !match_has_bit)
                              || (!match_found_ff && free_found_ff));
   assign idx_plus      = {1'b0, match_idx_ff} + {{IDX_W{1'b0}}, 1'b1};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (push_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: handshake, response and table write
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      push_rsp   = '0;
      wr_en      = 1'b0;
      wr_idx     = ev_idx_ff;
      wr_addr    = ent_addr;
      wr_bits    = ent_bits & ~mask_ff;
      wr_count   = (ent_count != '0) ? (ent_count - CNT_W'(1)) : ent_count;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_SCAN: begin
            // a newer list hit releases the held one
            push_valid         = need_push;
            push_rsp.status    = ST_OK;
            push_rsp.listed_ip = pend_ip_ff;
            // remove clears the module bit and decrements the count in place
            wr_en = (req_ff.operation == OP_REMOVE) && ev_valid_ff && hit.has_bit;
         end
         S_FINISH: begin
            push_valid    = 1'b1;
            push_rsp.last = 1'b1;
            case (req_ff.operation) inside
               OP_ADD: begin
                  if (!(|mask_ff)) begin
                     push_rsp.status = ST_NOT_FOUND;
                  end else if (match_found_ff || free_found_ff) begin
                     push_rsp.status = ST_OK;
                  end else begin
                     push_rsp.status = ST_FULL;
                  end
               end
               OP_REMOVE: begin
                  push_rsp.status = ST_OK;
               end
               OP_LOOKUP: begin
                  if (match_found_ff && (req_ff.ip_address != '0)
                      && (req_ff.ip_address != IP_ALL_ONES)) begin
                     push_rsp.status   = ST_OK;
                     push_rsp.if_index = IF_IDX_W'(idx_plus);
                  end else begin
                     push_rsp.status = ST_NOT_FOUND;
                  end
               end
               OP_LIST_MOD, OP_LIST_ALL: begin
                  if (pend_valid_ff) begin
                     push_rsp.status    = ST_OK;
                     push_rsp.listed_ip = pend_ip_ff;
                  end else begin
                     push_rsp.status = ST_LIST_EMPTY;
                  end
               end
               default: begin
                  push_rsp.status = ST_NOT_FOUND;
               end
            endcase
            // add claims or extends its entry as the response leaves
            wr_en    = add_write && push_ready;
            wr_idx   = match_found_ff ? match_idx_ff : free_idx_ff;
            wr_addr  = req_ff.ip_address;
            wr_bits  = (match_found_ff ? match_bits_ff : free_bits_ff) | mask_ff;
            wr_count = (match_found_ff ? match_count_ff : free_count_ff) + CNT_W'(1);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // request capture and scan bookkeeping
   always_comb begin
      req_in         = req_ff;
      mask_in        = mask_ff;
      lim_in         = lim_ff;
      rd_ptr_in      = rd_ptr_ff;
      ev_valid_in    = ev_valid_ff;
      ev_idx_in      = ev_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_bits_in  = match_bits_ff;
      match_count_in = match_count_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      free_bits_in   = free_bits_ff;
      free_count_in  = free_count_ff;
      pend_valid_in  = pend_valid_ff;
      pend_ip_in     = pend_ip_ff;
      taken_in       = taken_ff;
      if (accept) begin
         req_in         = req_payload;
         mask_in        = NUM_MODULES'(1) << req_payload.module_id;
         lim_in         = (req_payload.max_count > MAX_LIST) ? MAX_LIST : req_payload.max_count;
         rd_ptr_in      = '0;
         ev_valid_in    = 1'b0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         pend_valid_in  = 1'b0;
         taken_in       = '0;
      end else if ((state_ff == S_SCAN) && adv) begin
         // issue the next read
         if (rd_ptr_ff != PTR_END) begin
            ev_valid_in = 1'b1;
            ev_idx_in   = rd_idx;
            rd_ptr_in   = rd_ptr_ff + PTR_W'(1);
         end else begin
            ev_valid_in = 1'b0;
         end
         // judge the entry held in the read registers
         if (ev_valid_ff) begin
            if (hit.addr_eq && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = ev_idx_ff;
               match_bits_in  = ent_bits;
               match_count_in = ent_count;
            end
            if (hit.count_zero && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = ev_idx_ff;
               free_bits_in  = ent_bits;
               free_count_in = ent_count;
            end
            if (take) begin
               pend_valid_in = 1'b1;
               pend_ip_in    = ent_addr;
               taken_in      = taken_ff + LIMIT_W'(1);
            end
         end
      end
   end

   // written flags for every entry
   always_comb begin
      written_in = written_ff;
      if (wr_en) written_in[wr_idx] = 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         written_ff    <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rd_ptr_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         written_ff    <= written_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rd_ptr_ff     <= rd_ptr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      mask_ff        <= mask_in;
      lim_ff         <= lim_in;
      ev_idx_ff      <= ev_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      match_bits_ff  <= match_bits_in;
      match_count_ff <= match_count_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      free_bits_ff   <= free_bits_in;
      free_count_ff  <= free_count_in;
      pend_ip_ff     <= pend_ip_in;
      taken_ff       <= taken_in;
   end

   // table memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         addr_mem[wr_idx] <= wr_addr;
         bits_mem[wr_idx] <= wr_bits;
         cnt_mem[wr_idx]  <= wr_count;
      end
      if (rd_en) begin
         ev_addr_ff  <= addr_mem[rd_idx];
         ev_bits_ff  <= bits_mem[rd_idx];
         ev_count_ff <= cnt_mem[rd_idx];
         ev_known_ff <= written_ff[rd_idx];
      end
   end

endmodule

// ===== rtl/core/interface_address_registration_table_core.sv =====
// interface_address_registration_table_core: top level of the address table
// holds the response register; depends on iart_pkg, iart_seq and iart_match
//
//   channel   ports                               direction   moves
//   request   req_valid req_ready req_payload     in          one table operation
//   response  rsp_valid rsp_ready rsp_payload     out         one result, last on the final
//
// every request walks the whole table, one entry per cycle through the compare unit
// while the scan is not stalled, so each request finishes before the next is taken
// list requests hold one address back to mark the final one; a full response register
// stalls the scan when a later list hit releases the held one, and holds the finish cycle
// reset clears the per-entry written flags at once, so no clearing pass follows reset
// a new request is taken once the final response has entered the response register
module interface_address_registration_table_core #(
   parameter int NUM_ENTRIES = iart_pkg::NUM_ENTRIES_DEFAULT,
   parameter int NUM_MODULES = iart_pkg::NUM_MODULES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  iart_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output iart_pkg::rsp_type rsp_payload
);
   import iart_pkg::*;

   logic    push_valid;
   logic    push_ready;
   rsp_type push_rsp;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   iart_seq #(
      .NUM_ENTRIES(NUM_ENTRIES),
      .NUM_MODULES(NUM_MODULES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rsp   (push_rsp)
   );

   // response register refills in the cycle it drains
   assign push_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (push_valid && push_ready) begin
         out_valid_in = 1'b1;
         out_in       = push_rsp;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
